>>> src/clut_pkg.sv
// Shared types, operation codes and color helpers for the CLUT pixel converter.
// No dependencies; imported by clut_pixel_to_rgb565.
package clut_pkg;

    // One 8-bit color channel value.
    typedef logic [7:0] chan8_t;

    // Operation codes of an input request.
    localparam logic [1:0] OP_WRITE_ENTRY = 2'd0;
    localparam logic [1:0] OP_LINE_HEADER = 2'd1;
    localparam logic [1:0] OP_CONVERT     = 2'd2;

    // Table select codes of a table write.
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    // Source of the color parts of a converted pixel.
    localparam logic [1:0] SRC_BACKGROUND = 2'd0;
    localparam logic [1:0] SRC_FIXED      = 2'd1;
    localparam logic [1:0] SRC_LOOKUP     = 2'd2;

    localparam int TABLE_DEPTH = 32;

    // Widen a 5-bit field to 8 bits by replicating its top bits.
    function automatic chan8_t widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // Pack three 8-bit parts into RGB565.
    function automatic logic [15:0] pack565(input chan8_t r, input chan8_t g, input chan8_t b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

>>> src/clut_pixel_to_rgb565.sv
// Top level of the CLUT pixel converter: table storage and a three-stage pipeline.
// Depends on clut_pkg for operation codes, types and the widen and pack helpers.

// Each request carries an op code. Table writes and line headers take effect at the
// clock edge that accepts them and give no result; a convert request gives one RGB565
// result after stages 1 to 3. A pixel of zero takes the line background, a pixel
// with bit 15 set takes its own fields when the fixed palette is on, and any other
// pixel looks up its three 5-bit fields in the red, green and blue tables.
// The block takes one request per clock unless stalled: the tables are read in the
// cycle a request is accepted, then source selection and RGB565 packing each take
// one register stage. A stall holds only full stages, so bubbles are squeezed out.
module clut_pixel_to_rgb565
    import clut_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] pixel,
    input  logic [1:0]  table_select,
    input  logic [4:0]  entry_index,
    input  logic [7:0]  entry_value,
    input  logic [14:0] background,
    input  logic        fixed_enable,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] rgb565
);

    // Color tables and line state.
    chan8_t      red_table_reg   [TABLE_DEPTH];
    chan8_t      green_table_reg [TABLE_DEPTH];
    chan8_t      blue_table_reg  [TABLE_DEPTH];
    logic [14:0] line_bg_reg;
    logic        fixed_on_reg;

    // Stage 1: table reads and pixel class.
    logic        s1_valid_reg;
    logic [1:0]  s1_src_reg;
    chan8_t      s1_red_reg;
    chan8_t      s1_green_reg;
    chan8_t      s1_blue_reg;
    logic [14:0] s1_fields_reg;

    // Stage 2: selected 8-bit parts.
    logic        s2_valid_reg;
    chan8_t      s2_red_reg;
    chan8_t      s2_green_reg;
    chan8_t      s2_blue_reg;

    // Stage 3: packed output.
    logic        s3_valid_reg;
    logic [15:0] s3_rgb_reg;

    logic        adv1;
    logic        adv2;
    logic        adv3;
    logic        accept;
    logic        accept_convert;
    logic [1:0]  src_next;
    logic [14:0] fields_next;
    chan8_t      red_next;
    chan8_t      green_next;
    chan8_t      blue_next;

    // Each stage moves when it is empty or its successor moves.
    assign adv3           = !s3_valid_reg || out_ready;
    assign adv2           = !s2_valid_reg || adv3;
    assign adv1           = !s1_valid_reg || adv2;
    assign in_ready       = adv1;
    assign accept         = in_valid && in_ready;
    assign accept_convert = accept && (op == OP_CONVERT);

    // Table write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                red_table_reg[i]   <= '0;
                green_table_reg[i] <= '0;
                blue_table_reg[i]  <= '0;
            end
        end
        else if (accept && (op == OP_WRITE_ENTRY))
        begin
            unique case (table_select)
                SEL_RED:   red_table_reg[entry_index]   <= entry_value;
                SEL_GREEN: green_table_reg[entry_index] <= entry_value;
                SEL_BLUE:  blue_table_reg[entry_index]  <= entry_value;
                default:   ;
            endcase
        end
    end

    // Line header state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bg_reg  <= '0;
            fixed_on_reg <= 1'b0;
        end
        else if (accept && (op == OP_LINE_HEADER))
        begin
            line_bg_reg  <= background;
            fixed_on_reg <= fixed_enable;
        end
    end

    // Classify the pixel and read the tables with the state before this edge.
    always_comb
    begin
        red_next   = red_table_reg[pixel[14:10]];
        green_next = green_table_reg[pixel[9:5]];
        blue_next  = blue_table_reg[pixel[4:0]];
        priority if (pixel == 16'd0)
        begin
            src_next    = SRC_BACKGROUND;
            fields_next = line_bg_reg;
        end
        else if (fixed_on_reg && pixel[15])
        begin
            src_next    = SRC_FIXED;
            fields_next = pixel[14:0];
        end
        else
        begin
            src_next    = SRC_LOOKUP;
            fields_next = pixel[14:0];
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= accept_convert;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        if (accept_convert)
        begin
            s1_src_reg    <= src_next;
            s1_fields_reg <= fields_next;
            s1_red_reg    <= red_next;
            s1_green_reg  <= green_next;
            s1_blue_reg   <= blue_next;
        end
    end

    // Stage 2 payload: pick widened fields or table values.
    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            if (s1_src_reg == SRC_LOOKUP)
            begin
                s2_red_reg   <= s1_red_reg;
                s2_green_reg <= s1_green_reg;
                s2_blue_reg  <= s1_blue_reg;
            end
            else
            begin
                s2_red_reg   <= widen5(s1_fields_reg[14:10]);
                s2_green_reg <= widen5(s1_fields_reg[9:5]);
                s2_blue_reg  <= widen5(s1_fields_reg[4:0]);
            end
        end
    end

    // Stage 3 payload: pack to RGB565.
    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            s3_rgb_reg <= pack565(s2_red_reg, s2_green_reg, s2_blue_reg);
        end
    end

    assign out_valid = s3_valid_reg;
    assign rgb565    = s3_rgb_reg;

    // An empty output stage means the whole pipeline can take a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s3_valid_reg |-> in_ready)
        else $error("input not ready while output stage is empty");

    // An accepted convert request occupies stage 1 on the next cycle.
    a_convert_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept_convert |=> s1_valid_reg)
        else $error("accepted convert request lost at stage 1");

    // A stalled stage 2 keeps its item until stage 3 frees up.
    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !adv3) |=> s2_valid_reg)
        else $error("stage 2 item dropped during stall");

    // A line header loads the background register.
    a_header_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_LINE_HEADER)) |=>
            (line_bg_reg == $past(background)) && (fixed_on_reg == $past(fixed_enable)))
        else $error("line header not stored");

endmodule

>>> tb/clut_pixel_to_rgb565_tb.sv
// Self-checking testbench for the CLUT pixel to RGB565 converter.
// Depends on clut_pkg and clut_pixel_to_rgb565; a local color model predicts each result.
`timescale 1ns / 100ps

module clut_pixel_to_rgb565_tb
    import clut_pkg::*;
;

    // Codes outside the defined sets, which the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    // One input request as the driver presents it.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] pixel;
        logic [1:0]  table_select;
        logic [4:0]  entry_index;
        logic [7:0]  entry_value;
        logic [14:0] background;
        logic        fixed_enable;
    } clut_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_WRITE_ENTRY;
    logic [15:0] pixel = '0;
    logic [1:0]  table_select = SEL_RED;
    logic [4:0]  entry_index = '0;
    logic [7:0]  entry_value = '0;
    logic [14:0] background = '0;
    logic        fixed_enable = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] rgb565;

    // Requests waiting to be driven, and the request on the bus now.
    clut_req_t   pending_reqs[$];
    clut_req_t   bus_req = '0;

    // Converted pixels that the block still owes, oldest first.
    logic [15:0] rgb565_due[$];

    // Shadow copy of the color tables and line header.
    chan8_t      red_lut[TABLE_DEPTH];
    chan8_t      green_lut[TABLE_DEPTH];
    chan8_t      blue_lut[TABLE_DEPTH];
    logic [14:0] line_bg = '0;
    logic        fixed_on = 1'b0;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fail_count = 0;

    clut_pixel_to_rgb565 i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .pixel        (pixel),
        .table_select (table_select),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .background   (background),
        .fixed_enable (fixed_enable),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rgb565       (rgb565)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Replicate the top bits of a 5-bit field into the low bits of 8.
    function automatic chan8_t expand_field(input logic [4:0] f);
        return {f, f[4:2]};
    endfunction

    // Color of a pixel under the current tables and line header.
    function automatic logic [15:0] convert_pixel(input logic [15:0] px);
        chan8_t r;
        chan8_t g;
        chan8_t b;
        if (px == 16'h0000)
        begin
            r = expand_field(line_bg[14:10]);
            g = expand_field(line_bg[9:5]);
            b = expand_field(line_bg[4:0]);
        end
        else if (fixed_on && px[15])
        begin
            r = expand_field(px[14:10]);
            g = expand_field(px[9:5]);
            b = expand_field(px[4:0]);
        end
        else
        begin
            r = red_lut[px[14:10]];
            g = green_lut[px[9:5]];
            b = blue_lut[px[4:0]];
        end
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Apply an accepted request to the shadow state and queue its result, if any.
    task automatic track_request(input clut_req_t r);
        case (r.op)
            OP_WRITE_ENTRY:
            begin
                case (r.table_select)
                    SEL_RED:   red_lut[r.entry_index]   = r.entry_value;
                    SEL_GREEN: green_lut[r.entry_index] = r.entry_value;
                    SEL_BLUE:  blue_lut[r.entry_index]  = r.entry_value;
                    default:   ;
                endcase
            end
            OP_LINE_HEADER:
            begin
                line_bg  = r.background;
                fixed_on = r.fixed_enable;
            end
            OP_CONVERT:
            begin
                rgb565_due.push_back(convert_pixel(r.pixel));
            end
            default: ;
        endcase
    endtask

    // Build a request from its fields.
    function automatic clut_req_t make_req(input logic [1:0] o, input logic [15:0] px,
                                           input logic [1:0] sel, input logic [4:0] idx,
                                           input logic [7:0] val, input logic [14:0] bg,
                                           input logic fe);
        clut_req_t r;
        r.op           = o;
        r.pixel        = px;
        r.table_select = sel;
        r.entry_index  = idx;
        r.entry_value  = val;
        r.background   = bg;
        r.fixed_enable = fe;
        return r;
    endfunction

    // Short directed sequence: field extremes, every op and the corner cases.
    task automatic queue_directed();
        // Reset tables and header, before any write.
        pending_reqs.push_back(make_req(OP_CONVERT, 16'h0000, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_CONVERT, 16'hFFFF, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        // Table entries at both ends of the index and value ranges.
        pending_reqs.push_back(make_req(OP_WRITE_ENTRY, 16'hFFFF, SEL_RED, 5'd0, 8'hFF,
                                        15'h7FFF, 1'b1));
        pending_reqs.push_back(make_req(OP_WRITE_ENTRY, 16'h0000, SEL_GREEN, 5'd0, 8'hFF,
                                        '0, 1'b0));
        pending_reqs.push_back(make_req(OP_WRITE_ENTRY, 16'h0000, SEL_BLUE, 5'd0, 8'hFF,
                                        '0, 1'b0));
        pending_reqs.push_back(make_req(OP_WRITE_ENTRY, 16'h0000, SEL_RED, 5'd31, 8'hA5,
                                        '0, 1'b0));
        pending_reqs.push_back(make_req(OP_WRITE_ENTRY, 16'h0000, SEL_GREEN, 5'd31, 8'h5A,
                                        '0, 1'b0));
        pending_reqs.push_back(make_req(OP_WRITE_ENTRY, 16'h0000, SEL_BLUE, 5'd31, 8'h00,
                                        '0, 1'b0));
        // A write with no table selected changes nothing.
        pending_reqs.push_back(make_req(OP_WRITE_ENTRY, 16'h0000, SEL_NONE, 5'd0, 8'h00,
                                        '0, 1'b0));
        // An unused op code changes nothing and gives no result.
        pending_reqs.push_back(make_req(OP_UNUSED, 16'h0000, SEL_RED, 5'd0, 8'h00,
                                        15'h7FFF, 1'b1));
        // Bit 15 alone with the fixed palette off looks up entry zero.
        pending_reqs.push_back(make_req(OP_CONVERT, 16'h8000, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_CONVERT, 16'h7FFF, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_CONVERT, 16'hFFFF, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        // Full white background with the fixed palette on.
        pending_reqs.push_back(make_req(OP_LINE_HEADER, 16'h0000, SEL_RED, 5'd0, 8'd0,
                                        15'h7FFF, 1'b1));
        pending_reqs.push_back(make_req(OP_CONVERT, 16'h0000, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        // Bit 15 alone with the fixed palette on gives black.
        pending_reqs.push_back(make_req(OP_CONVERT, 16'h8000, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_CONVERT, 16'hFFFF, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_CONVERT, 16'h7FFF, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_CONVERT, 16'hC210, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        // Back to a black background with the fixed palette off.
        pending_reqs.push_back(make_req(OP_LINE_HEADER, 16'h0000, SEL_RED, 5'd0, 8'd0,
                                        15'h0000, 1'b0));
        pending_reqs.push_back(make_req(OP_CONVERT, 16'h0000, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_CONVERT, 16'h83FF, SEL_RED, 5'd0, 8'd0, '0, 1'b0));
    endtask

    // Random requests; ignored op codes are sprinkled in but not counted.
    task automatic queue_random(input int count);
        int        done;
        int        pick;
        clut_req_t r;
        done = 0;
        while (done < count)
        begin
            r = clut_req_t'({$urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 28)
            begin
                r.op = OP_WRITE_ENTRY;
                if ($urandom_range(0, 9) == 0)
                    r.table_select = SEL_NONE;
                else
                    r.table_select = 2'($urandom_range(0, 2));
            end
            else if (pick < 38)
                r.op = OP_LINE_HEADER;
            else if (pick < 96)
            begin
                r.op = OP_CONVERT;
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    r.pixel = 16'h0000;
                else if (pick < 4)
                    r.pixel = 16'h8000;
            end
            else
                r.op = OP_UNUSED;
            pending_reqs.push_back(r);
            if (r.op != OP_UNUSED)
                done++;
        end
    endtask

    // Wait until every queued request has been taken by the block.
    task automatic wait_requests_taken();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid);
    endtask

    // Request driver: holds each request until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        clut_req_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_request(bus_req);
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    r = pending_reqs.pop_front();
                    bus_req      <= r;
                    op           <= r.op;
                    pixel        <= r.pixel;
                    table_select <= r.table_select;
                    entry_index  <= r.entry_index;
                    entry_value  <= r.entry_value;
                    background   <= r.background;
                    fixed_enable <= r.fixed_enable;
                    in_valid     <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted pixel with the oldest one due.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        logic [15:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rgb565_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result rgb565=%h at %0t", rgb565, $realtime);
                    fail_count++;
                end
                else
                begin
                    want = rgb565_due.pop_front();
                    if (rgb565 !== want)
                    begin
                        if (fail_count < 10)
                            $display("rgb565 mismatch: expected %h, got %h at %0t",
                                     want, rgb565, $realtime);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin : run_test
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            red_lut[i]   = '0;
            green_lut[i] = '0;
            blue_lut[i]  = '0;
        end

        // Slow sender, mostly stalled receiver, with the directed part first.
        send_idle_pct = 21;
        recv_idle_pct = 75;
        queue_directed();
        queue_random(440);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait_requests_taken();

        // Mostly idle sender, slightly stalled receiver.
        send_idle_pct = 75;
        recv_idle_pct = 21;
        queue_random(440);
        wait_requests_taken();

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(450);
        wait_requests_taken();

        while (rgb565_due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (fail_count == 0 && rgb565_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
